>>> hdl/cdtp_pkg.sv
// Shared types, constants and the CRC update for the CD-Text pack validator.
package cdtp_pkg;

    localparam logic [16:0] HDR_LEN      = 17'd4;
    localparam logic [16:0] MIN_LEN      = 17'd22;
    localparam logic [16:0] CNT_MAX      = 17'h1ffff;
    localparam logic [11:0] IDX_MAX      = 12'hfff;
    localparam logic [4:0]  POS_CRC_HI   = 5'd16;
    localparam logic [4:0]  POS_CRC_LO   = 5'd17;
    localparam logic [7:0]  INFO_PACK_ID = 8'h8f;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_INIT     = 16'h0000;
    localparam int          QUEUE_DEPTH  = 4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_STRUCT = 2'd1;
    localparam logic [1:0] ST_SHORT  = 2'd2;
    localparam logic [1:0] ST_CRC    = 2'd3;

    typedef struct packed {
        logic [7:0]  last_track;
        logic [7:0]  first_track;
        logic        info_found;
        logic [11:0] bad_pack_index;
        logic [11:0] recomputed_count;
        logic [11:0] pack_count;
        logic [1:0]  status;
        logic        done_res;
        logic        byte_valid;
        logic [7:0]  data_byte;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> hdl/cdtp_engine.sv
// Per-byte parse, CRC check and status logic for the CD-Text pack validator.
module cdtp_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        in_byte,
    input  logic              last,
    output cdtp_pkg::push_t   push
);
    import cdtp_pkg::*;

    logic [16:0] total_count_reg, total_count_next;
    logic [15:0] header_length_reg, header_length_next;
    logic [4:0]  pos_reg, pos_next;
    logic [15:0] crc_acc_reg, crc_acc_next;
    logic [7:0]  held_crc_high_reg, held_crc_high_next;
    logic [11:0] pack_index_reg, pack_index_next;
    logic [11:0] fix_count_reg, fix_count_next;
    logic        damage_seen_reg, damage_seen_next;
    logic [11:0] damage_index_reg, damage_index_next;
    logic        is_info_reg, is_info_next;
    logic [15:0] cand_tracks_reg, cand_tracks_next;
    logic        si_latched_reg, si_latched_next;
    logic [15:0] latched_tracks_reg, latched_tracks_next;

    logic [15:0] stored;
    logic [15:0] want;
    logic [7:0]  d0;
    logic [7:0]  d1;
    logic [1:0]  n;
    logic [1:0]  st;
    res_t        fin;

    always_comb
    begin
        total_count_next    = total_count_reg;
        header_length_next  = header_length_reg;
        pos_next            = pos_reg;
        crc_acc_next        = crc_acc_reg;
        held_crc_high_next  = held_crc_high_reg;
        pack_index_next     = pack_index_reg;
        fix_count_next      = fix_count_reg;
        damage_seen_next    = damage_seen_reg;
        damage_index_next   = damage_index_reg;
        is_info_next        = is_info_reg;
        cand_tracks_next    = cand_tracks_reg;
        si_latched_next     = si_latched_reg;
        latched_tracks_next = latched_tracks_reg;
        stored = {held_crc_high_reg, in_byte};
        want   = ~crc_acc_reg;
        d0     = in_byte;
        d1     = in_byte;
        n      = 2'd0;
        st     = ST_OK;
        fin    = '0;
        push   = '0;

        if (fire)
        begin
            if (total_count_reg < HDR_LEN)
            begin
                if (total_count_reg < 17'd2)
                begin
                    header_length_next = {header_length_reg[7:0], in_byte};
                end
                n = 2'd1;
            end
            else if (pos_reg < POS_CRC_HI)
            begin
                case (pos_reg)
                    5'd0:
                    begin
                        is_info_next = (in_byte == INFO_PACK_ID);
                    end
                    5'd1:
                    begin
                        if (in_byte[7])
                        begin
                            is_info_next = 1'b0;
                        end
                    end
                    5'd3:
                    begin
                        if (in_byte[6:4] != 3'd0)
                        begin
                            is_info_next = 1'b0;
                        end
                    end
                    5'd5:
                    begin
                        cand_tracks_next = {in_byte, cand_tracks_reg[7:0]};
                    end
                    5'd6:
                    begin
                        cand_tracks_next = {cand_tracks_reg[15:8], in_byte};
                    end
                    default:
                    begin
                    end
                endcase
                crc_acc_next = crc_update((pos_reg == 5'd0) ? CRC_INIT : crc_acc_reg, in_byte);
                pos_next     = pos_reg + 5'd1;
                n            = 2'd1;
            end
            else if (pos_reg == POS_CRC_HI)
            begin
                held_crc_high_next = in_byte;
                pos_next           = POS_CRC_LO;
                n                  = last ? 2'd1 : 2'd0;
            end
            else
            begin
                if (!damage_seen_reg && stored != want)
                begin
                    if (stored == 16'h0000)
                    begin
                        stored = want;
                        if (fix_count_reg < IDX_MAX)
                        begin
                            fix_count_next = fix_count_reg + 12'd1;
                        end
                    end
                    else
                    begin
                        damage_seen_next  = 1'b1;
                        damage_index_next = pack_index_reg;
                    end
                end
                if (!damage_seen_next && !si_latched_reg && is_info_reg)
                begin
                    si_latched_next     = 1'b1;
                    latched_tracks_next = cand_tracks_reg;
                end
                d0       = stored[15:8];
                d1       = stored[7:0];
                pos_next = 5'd0;
                if (pack_index_reg < IDX_MAX)
                begin
                    pack_index_next = pack_index_reg + 12'd1;
                end
                n = 2'd2;
            end

            if (total_count_reg != CNT_MAX)
            begin
                total_count_next = total_count_reg + 17'd1;
            end

            if (total_count_next < MIN_LEN)
            begin
                st = ST_SHORT;
            end
            else if (pos_next != 5'd0)
            begin
                st = ST_STRUCT;
            end
            else if ({1'b0, header_length_next} != total_count_next - 17'd2)
            begin
                st = ST_STRUCT;
            end
            else
            begin
                st = damage_seen_next ? ST_CRC : ST_OK;
            end

            fin.done_res = 1'b1;
            fin.status   = st;
            if (st == ST_OK || st == ST_CRC)
            begin
                fin.pack_count       = pack_index_next;
                fin.recomputed_count = fix_count_next;
                fin.bad_pack_index   = (st == ST_CRC) ? damage_index_next : 12'd0;
                fin.info_found       = si_latched_next;
                fin.first_track      = si_latched_next ? latched_tracks_next[15:8] : 8'd0;
                fin.last_track       = si_latched_next ? latched_tracks_next[7:0] : 8'd0;
            end

            push.n  = n;
            push.r0 = (last && n == 2'd1) ? fin : '0;
            push.r1 = (last && n == 2'd2) ? fin : '0;
            push.r0.data_byte  = d0;
            push.r0.byte_valid = 1'b1;
            push.r1.data_byte  = d1;
            push.r1.byte_valid = 1'b1;

            if (last)
            begin
                total_count_next    = '0;
                header_length_next  = '0;
                pos_next            = '0;
                crc_acc_next        = '0;
                held_crc_high_next  = '0;
                pack_index_next     = '0;
                fix_count_next      = '0;
                damage_seen_next    = 1'b0;
                damage_index_next   = '0;
                is_info_next        = 1'b0;
                cand_tracks_next    = '0;
                si_latched_next     = 1'b0;
                latched_tracks_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_count_reg    <= '0;
            header_length_reg  <= '0;
            pos_reg            <= '0;
            crc_acc_reg        <= '0;
            held_crc_high_reg  <= '0;
            pack_index_reg     <= '0;
            fix_count_reg      <= '0;
            damage_seen_reg    <= 1'b0;
            damage_index_reg   <= '0;
            is_info_reg        <= 1'b0;
            cand_tracks_reg    <= '0;
            si_latched_reg     <= 1'b0;
            latched_tracks_reg <= '0;
        end
        else
        begin
            total_count_reg    <= total_count_next;
            header_length_reg  <= header_length_next;
            pos_reg            <= pos_next;
            crc_acc_reg        <= crc_acc_next;
            held_crc_high_reg  <= held_crc_high_next;
            pack_index_reg     <= pack_index_next;
            fix_count_reg      <= fix_count_next;
            damage_seen_reg    <= damage_seen_next;
            damage_index_reg   <= damage_index_next;
            is_info_reg        <= is_info_next;
            cand_tracks_reg    <= cand_tracks_next;
            si_latched_reg     <= si_latched_next;
            latched_tracks_reg <= latched_tracks_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_CRC_LO)
        else $error("pack byte position out of range");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> total_count_reg == 17'd0 && pos_reg == 5'd0)
        else $error("state not cleared after final item");

    a_crc_pair: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pos_reg == POS_CRC_LO |-> push.n == 2'd2)
        else $error("CRC pair not emitted together");

endmodule

>>> hdl/cdtp_queue.sv
// Four-entry result queue that takes up to two results per cycle.
module cdtp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  cdtp_pkg::push_t  push,
    input  logic             pop,
    output logic             room,
    output logic             head_valid,
    output cdtp_pkg::res_t   head
);
    import cdtp_pkg::*;

    res_t       entry_reg [QUEUE_DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;

    assign room       = (count_reg <= 3'd2);
    assign head_valid = (count_reg != 3'd0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.n;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push.n} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            entry_reg[wr_ptr_reg + 2'd1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> count_reg <= 3'd2)
        else $error("push without room");

    a_pop_drain: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.n == 2'd0 |=> count_reg == $past(count_reg) - 3'd1)
        else $error("pop did not drain queue");

endmodule

>>> hdl/cdtext_pack_stream_validator_core.sv
// Path: a byte is captured in the input register, and its results are written into the result queue.
// Throughput: one byte per cycle while the result queue has room; CRC byte pairs enter the four-entry queue together.
// Input stalls only while the result queue holds more than two results.
// Reset: rst_n is asynchronous and clears all parse state and the queue.
// After the final byte of a blob the parse state returns to its reset values.
// Top level of the CD-Text pack stream validator.
module cdtext_pack_stream_validator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data_byte, status, pack_count, recomputed_count, bad_pack_index,
    // info_found, first_track, last_track, zero pad
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser,   // byte_valid
    output logic        m_axis_tlast    // done_res
);
    import cdtp_pkg::*;

    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    logic            in_last_reg;
    logic            room;
    logic            fire;
    logic            head_valid;
    push_t           push;
    res_t            head;

    assign fire          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    cdtp_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_byte (in_byte_reg),
        .last    (in_last_reg),
        .push    (push)
    );

    cdtp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (m_axis_tvalid && m_axis_tready),
        .room       (room),
        .head_valid (head_valid),
        .head       (head)
    );

    assign m_axis_tvalid = head_valid;
    assign m_axis_tuser  = head.byte_valid;
    assign m_axis_tlast  = head.done_res;
    assign m_axis_tdata  = {1'b0, head.last_track, head.first_track, head.info_found,
                            head.bad_pack_index, head.recomputed_count, head.pack_count,
                            head.status, head.data_byte};

endmodule

>>> test/tb_cdtext_pack_stream_validator_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the CD-Text pack stream validator: blobs in, checked bytes and status out.
module tb_cdtext_pack_stream_validator_core;
    import cdtp_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 20;
    localparam int PACK_BYTES   = 18;
    localparam int LONG_PACKS   = 12;

    typedef enum {CRC_GOOD, CRC_ZERO, CRC_BAD} crc_pick_t;
    typedef enum {BLOB_GOOD, BLOB_HDR_MISMATCH, BLOB_RAGGED, BLOB_SHORT, BLOB_NOISE} blob_kind_t;

    typedef struct {
        logic [7:0] in_byte;
        logic       last;
        bit         typed;
        res_t       result;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    logic [16:0] byte_total;
    logic [15:0] hdr_length;
    logic [4:0]  pack_pos;
    logic [15:0] run_crc;
    logic [7:0]  crc_high;
    logic [11:0] packs_seen;
    logic [11:0] fixes_made;
    logic        damaged;
    logic [11:0] damaged_pack;
    logic        is_info_pack;
    logic [15:0] cand_tracks;
    logic        tracks_latched;
    logic [15:0] track_pair;

    res_t       step_res[2];
    res_t       expected_bytes[$];
    logic [7:0] blob[$];
    stim_row_t  directed[$];
    int         mismatches = 0;
    int         cycles = 0;
    int         sink_stall = 0;
    int         random_sent = 0;
    bit         calm = 1'b0;

    cdtext_pack_stream_validator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    function automatic void clear_tracker();
        byte_total     = '0;
        hdr_length     = '0;
        pack_pos       = '0;
        run_crc        = '0;
        crc_high       = '0;
        packs_seen     = '0;
        fixes_made     = '0;
        damaged        = 1'b0;
        damaged_pack   = '0;
        is_info_pack   = 1'b0;
        cand_tracks    = '0;
        tracks_latched = 1'b0;
        track_pair     = '0;
    endfunction

    function automatic logic [15:0] ccitt_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic res_t byte_res(input logic [7:0] b);
        res_t r;
        r = '0;
        r.data_byte = b;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    function automatic stim_row_t mk_row(input logic [7:0] b, input logic l, input bit typed);
        stim_row_t row;
        row.in_byte = b;
        row.last = l;
        row.typed = typed;
        row.result = byte_res(b);
        row.result.done_res = l;
        row.result.status = l ? ST_SHORT : ST_OK;
        return row;
    endfunction

    // Returns how many result items the byte causes, filling step_res.
    function automatic int validate_byte(input logic [7:0] b, input logic l);
        int          n;
        int          k;
        logic [15:0] stored;
        logic [15:0] want;
        logic [16:0] len;
        logic [1:0]  st;
        n = 0;
        if (byte_total < HDR_LEN) begin
            if (byte_total < 17'd2)
                hdr_length = {hdr_length[7:0], b};
            step_res[0] = byte_res(b);
            n = 1;
        end
        else if (pack_pos < POS_CRC_HI) begin
            case (pack_pos)
                5'd0:
                begin
                    run_crc = CRC_INIT;
                    is_info_pack = (b == INFO_PACK_ID);
                end
                5'd1: if (b[7]) is_info_pack = 1'b0;
                5'd3: if (b[6:4] != 3'b000) is_info_pack = 1'b0;
                5'd5: cand_tracks[15:8] = b;
                5'd6: cand_tracks[7:0] = b;
                default: ;
            endcase
            run_crc = ccitt_next(run_crc, b);
            step_res[0] = byte_res(b);
            n = 1;
            pack_pos = pack_pos + 5'd1;
        end
        else if (pack_pos == POS_CRC_HI) begin
            crc_high = b;
            pack_pos = POS_CRC_LO;
            if (l) begin
                step_res[0] = byte_res(b);
                n = 1;
            end
        end
        else begin
            stored = {crc_high, b};
            want = ~run_crc;
            if (!damaged && stored != want) begin
                if (stored == 16'h0000) begin
                    stored = want;
                    if (fixes_made != IDX_MAX)
                        fixes_made = fixes_made + 12'd1;
                end
                else begin
                    damaged = 1'b1;
                    damaged_pack = packs_seen;
                end
            end
            if (!damaged && !tracks_latched && is_info_pack) begin
                tracks_latched = 1'b1;
                track_pair = cand_tracks;
            end
            step_res[0] = byte_res(stored[15:8]);
            step_res[1] = byte_res(stored[7:0]);
            n = 2;
            pack_pos = '0;
            if (packs_seen != IDX_MAX)
                packs_seen = packs_seen + 12'd1;
        end
        if (byte_total != CNT_MAX)
            byte_total = byte_total + 17'd1;
        if (l) begin
            k = n - 1;
            len = byte_total;
            if (len < MIN_LEN)
                st = ST_SHORT;
            else if ((len - HDR_LEN) % PACK_BYTES != 0)
                st = ST_STRUCT;
            else if ({1'b0, hdr_length} != len - 17'd2)
                st = ST_STRUCT;
            else
                st = damaged ? ST_CRC : ST_OK;
            step_res[k].done_res = 1'b1;
            step_res[k].status = st;
            if (st == ST_OK || st == ST_CRC) begin
                step_res[k].pack_count = packs_seen;
                step_res[k].recomputed_count = fixes_made;
                step_res[k].bad_pack_index = (st == ST_CRC) ? damaged_pack : 12'd0;
                step_res[k].info_found = tracks_latched;
                step_res[k].first_track = tracks_latched ? track_pair[15:8] : 8'h00;
                step_res[k].last_track = tracks_latched ? track_pair[7:0] : 8'h00;
            end
            clear_tracker();
        end
        return n;
    endfunction

    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int field_diff(input string tag, input logic [15:0] want,
                                      input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                             input res_t typed_res);
        int gap;
        int n;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= l;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        n = validate_byte(b, l);
        if (typed)
            expected_bytes.push_back(typed_res);
        else
            for (int i = 0; i < n; i++)
                expected_bytes.push_back(step_res[i]);
    endtask

    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_bytes.size() != 0);
    endtask

    task automatic send_blob();
        for (int i = 0; i < blob.size(); i++)
            send_byte(blob[i], i == blob.size() - 1, 1'b0, '0);
    endtask

    task automatic add_pack(input bit want_info, input crc_pick_t mode);
        logic [7:0]  p[16];
        logic [15:0] c;
        logic [15:0] stored;
        c = CRC_INIT;
        foreach (p[i])
            p[i] = 8'($urandom_range(0, 255));
        if (want_info) begin
            p[0] = INFO_PACK_ID;
            if ($urandom_range(0, 3) != 0)
                p[1][7] = 1'b0;
            if ($urandom_range(0, 3) != 0)
                p[3][6:4] = 3'b000;
        end
        foreach (p[i])
        begin
            c = ccitt_next(c, p[i]);
            blob.push_back(p[i]);
        end
        case (mode)
            CRC_GOOD: stored = ~c;
            CRC_ZERO: stored = 16'h0000;
            default:  stored = 16'($urandom_range(1, 16'hffff));
        endcase
        blob.push_back(stored[15:8]);
        blob.push_back(stored[7:0]);
    endtask

    task automatic build_blob(input blob_kind_t kind);
        int          npacks;
        int          extra;
        int          total;
        int          r;
        logic [15:0] hdr_val;
        blob.delete();
        if (kind == BLOB_SHORT || kind == BLOB_NOISE) begin
            total = (kind == BLOB_SHORT) ? $urandom_range(1, 21) : $urandom_range(1, 90);
            repeat (total) blob.push_back(8'($urandom_range(0, 255)));
            if (total >= 2 && $urandom_range(0, 1) == 1) begin
                hdr_val = 16'(total - 2);
                blob[0] = hdr_val[15:8];
                blob[1] = hdr_val[7:0];
            end
        end
        else begin
            npacks = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
            repeat (4) blob.push_back(8'($urandom_range(0, 255)));
            repeat (npacks)
            begin
                r = $urandom_range(0, 9);
                add_pack($urandom_range(0, 2) == 0,
                         (r < 5) ? CRC_GOOD : ((r < 8) ? CRC_ZERO : CRC_BAD));
            end
            if (kind == BLOB_RAGGED) begin
                extra = ($urandom_range(0, 2) == 0) ? 17 : $urandom_range(1, 16);
                repeat (extra) blob.push_back(8'($urandom_range(0, 255)));
            end
            hdr_val = 16'(blob.size() - 2);
            if (kind == BLOB_HDR_MISMATCH)
                hdr_val = hdr_val ^ 16'($urandom_range(1, 16'hffff));
            blob[0] = hdr_val[15:8];
            blob[1] = hdr_val[7:0];
        end
    endtask

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (sink_stall > 0) begin
            m_axis_tready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end
        else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                sink_stall <= idle_len();
        end
    end

    always @(posedge clk) begin : result_check
        res_t want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: item with nothing expected, expected none, actual %h/%b/%b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else begin
                want = expected_bytes.pop_front();
                mismatches += field_diff("data_byte", 16'(want.data_byte),
                                         16'(m_axis_tdata[7:0]));
                mismatches += field_diff("byte_valid", 16'(want.byte_valid),
                                         16'(m_axis_tuser));
                mismatches += field_diff("done_res", 16'(want.done_res), 16'(m_axis_tlast));
                mismatches += field_diff("status", 16'(want.status), 16'(m_axis_tdata[9:8]));
                mismatches += field_diff("pack_count", 16'(want.pack_count),
                                         16'(m_axis_tdata[21:10]));
                mismatches += field_diff("recomputed_count", 16'(want.recomputed_count),
                                         16'(m_axis_tdata[33:22]));
                mismatches += field_diff("bad_pack_index", 16'(want.bad_pack_index),
                                         16'(m_axis_tdata[45:34]));
                mismatches += field_diff("info_found", 16'(want.info_found),
                                         16'(m_axis_tdata[46]));
                mismatches += field_diff("first_track", 16'(want.first_track),
                                         16'(m_axis_tdata[54:47]));
                mismatches += field_diff("last_track", 16'(want.last_track),
                                         16'(m_axis_tdata[62:55]));
            end
        end
    end

    initial begin
        logic [7:0]  hdr_bytes[4];
        logic [7:0]  info_pack[18];
        logic [15:0] long_hdr;
        int          r;
        hdr_bytes = '{8'h00, 8'h14, 8'h00, 8'h00};
        info_pack = '{8'h8f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h63, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        directed.push_back(mk_row(8'hff, 1'b1, 1'b1));
        directed.push_back(mk_row(8'h00, 1'b1, 1'b1));
        foreach (hdr_bytes[i])
            directed.push_back(mk_row(hdr_bytes[i], 1'b0, 1'b1));
        foreach (info_pack[i])
            directed.push_back(mk_row(info_pack[i], i == 17, 1'b0));
        clear_tracker();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_byte(directed[i].in_byte, directed[i].last, directed[i].typed,
                      directed[i].result);
        drain_wait();

        // long blob, damage on the final pack
        calm = 1'b1;
        blob.delete();
        repeat (4) blob.push_back(8'h00);
        for (int i = 0; i < LONG_PACKS; i++)
            add_pack(i < 3, (i == LONG_PACKS - 1) ? CRC_BAD :
                            (($urandom_range(0, 7) == 0) ? CRC_GOOD : CRC_ZERO));
        long_hdr = 16'(blob.size() - 2);
        blob[0] = long_hdr[15:8];
        blob[1] = long_hdr[7:0];
        send_blob();
        drain_wait();

        while (random_sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 60)
                build_blob(BLOB_GOOD);
            else if (r < 70)
                build_blob(BLOB_HDR_MISMATCH);
            else if (r < 80)
                build_blob(BLOB_RAGGED);
            else if (r < 90)
                build_blob(BLOB_SHORT);
            else
                build_blob(BLOB_NOISE);
            send_blob();
            random_sent += blob.size();
            if ($urandom_range(0, 5) == 0)
                drain_wait();
        end

        calm = 1'b0;
        drain_wait();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
hdl/cdtp_pkg.sv
hdl/cdtp_engine.sv
hdl/cdtp_queue.sv
hdl/cdtext_pack_stream_validator_core.sv
test/tb_cdtext_pack_stream_validator_core.sv
